// ----- rtl/pcicfg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared types and constants of the configuration-mechanism port with its
// attached device configuration space.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

	// Access kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_ADDR_WR = 2'd0,
		KIND_ADDR_RD = 2'd1,
		KIND_DATA_WR = 2'd2,
		KIND_DATA_RD = 2'd3
	} kind_t;

	// Configuration register indexes (paddr bit 2)
	localparam logic REG_BOARD_TYPE  = 1'b0;
	localparam logic REG_DEVICE_SLOT = 1'b1;

	// Board generations
	localparam logic [1:0] BOARD_GEN2 = 2'd2;

	// Device constants
	localparam logic [31:0] INITIAL_BAR   = 32'hD000_0000;
	localparam logic [15:0] VENDOR_ID     = 16'h121a;
	localparam logic [7:0]  CMD_LOW_RST   = 8'h02;
	localparam logic [7:0]  CMD_LOW_MASK  = 8'h23;
	localparam logic [7:0]  CMD_HIGH_MASK = 8'h01;
	localparam logic [7:0]  BAR_LOW_BYTE  = (INITIAL_BAR[7:0] & 8'hf0) | 8'h08;

	// Register offsets in configuration space
	localparam logic [7:0] OFF_VENDOR_LO = 8'h00;
	localparam logic [7:0] OFF_VENDOR_HI = 8'h01;
	localparam logic [7:0] OFF_DEVICE_ID = 8'h02;
	localparam logic [7:0] OFF_CMD_LOW   = 8'h04;
	localparam logic [7:0] OFF_CMD_HIGH  = 8'h05;
	localparam logic [7:0] OFF_STATUS_HI = 8'h06;
	localparam logic [7:0] OFF_REV       = 8'h08;
	localparam logic [7:0] OFF_CLASS     = 8'h0b;
	localparam logic [7:0] OFF_BAR0      = 8'h10;
	localparam logic [7:0] OFF_BAR1      = 8'h11;
	localparam logic [7:0] OFF_BAR2      = 8'h12;
	localparam logic [7:0] OFF_BAR3      = 8'h13;
	localparam logic [7:0] OFF_INT_LINE  = 8'h3c;
	localparam logic [7:0] OFF_INIT_EN   = 8'h40;
	localparam logic [7:0] OFF_EXT1      = 8'h41;
	localparam logic [7:0] OFF_EXT2      = 8'h42;
	localparam logic [7:0] OFF_OSC_LO    = 8'h54;
	localparam logic [7:0] OFF_OSC_HI    = 8'h55;
	localparam logic [7:0] OFF_BUS_LO    = 8'h56;
	localparam logic [7:0] OFF_BUS_HI    = 8'h57;
	localparam logic [7:0] OFF_ENABLE    = 8'hc0;
	localparam logic [7:0] OFF_DISABLE   = 8'he0;

	// Byte returned for an access that no device claims
	localparam logic [7:0] NO_DEVICE_BYTE = 8'hff;

	typedef struct packed {
		logic [1:0] board_type;
		logic [4:0] device_slot;
	} cfg_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bar_changed;
		logic [31:0] bar_base;
		logic        init_enable_pulse;
		logic [2:0]  init_enable_value;
		logic        enable_pulse;
		logic        enable_value;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

// ----- rtl/pci_config_port_with_device_core.sv -----
// ----------------------------------------------------------------------------
// pci_config_port_with_device_core
// Configuration mechanism 1 host port joined to one device configuration
// space, with an APB register port for board type and device slot.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is one access: an address-port write or
// read, or a byte write or read on the data port. One beat is taken every
// clock unless both result slots are full; each result is registered, and
// the two-deep result buffer keeps the input open while one result waits.
// Data-port accesses reach the device only when bit 31 of the address word
// is set, the bus number is 0 and the device number matches device_slot;
// otherwise reads return 0xff and writes are dropped. Every result carries
// the current BAR base. Write board_type and device_slot only while no
// access is in flight.
module pci_config_port_with_device_core
	import pcicfg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Access stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // lane[1:0], data[33:2], zero pad
	input  logic [1:0]  s_tuser,  // kind[1:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // read_data[31:0], bar_changed[32],
	                              // bar_base[64:33], init_enable_pulse[65],
	                              // init_enable_value[68:66], enable_pulse[69],
	                              // enable_value[70], zero pad
);

	cfg_t cfg_q;
	res_t res;
	res_t out_res;
	logic accept;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_type  <= 2'd1;
			cfg_q.device_slot <= 5'd0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BOARD_TYPE:  cfg_q.board_type  <= pwdata[1:0];
				REG_DEVICE_SLOT: cfg_q.device_slot <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[2])
			REG_BOARD_TYPE:  prdata = {30'd0, cfg_q.board_type};
			REG_DEVICE_SLOT: prdata = {27'd0, cfg_q.device_slot};
			default:         prdata = '0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	pcicfg_space u_space (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.kind   (kind_t'(s_tuser)),
		.lane   (s_tdata[1:0]),
		.data   (s_tdata[33:2]),
		.res    (res)
	);

	pcicfg_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Result beat packing
	assign m_tdata = {1'b0,
		out_res.enable_value,
		out_res.enable_pulse,
		out_res.init_enable_value,
		out_res.init_enable_pulse,
		out_res.bar_base,
		out_res.bar_changed,
		out_res.read_data};

endmodule

// ----- rtl/pcicfg_space.sv -----
// ----------------------------------------------------------------------------
// pcicfg_space
// Address register, decode and device configuration space. Computes the
// result of one access and updates state at the edge the access is taken.
// ----------------------------------------------------------------------------
module pcicfg_space
	import pcicfg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  kind_t       kind,
	input  logic [1:0]  lane,
	input  logic [31:0] data,
	output res_t        res
);

	logic [31:0] address_q;
	logic [7:0]  cmd_low_q;
	logic [7:0]  cmd_high_q;
	logic [7:0]  bar_top_q;
	logic [15:0] osc_q;
	logic [11:0] bus_q;

	logic        addressed;
	logic        second;
	logic [7:0]  off;
	logic [15:0] osc_inc;
	logic [11:0] bus_dec;
	logic [7:0]  rd_byte;
	logic        wr_hit;
	logic        rd_hit;
	logic        cnt_hit;
	logic [7:0]  bar_top_next;

	// Decode of the latched address word
	assign addressed = address_q[31] && (address_q[23:16] == 8'd0)
		&& (address_q[15:11] == cfg.device_slot);
	assign second  = (cfg.board_type == BOARD_GEN2);
	assign off     = {address_q[7:2], lane};
	assign osc_inc = osc_q + 16'd1;
	assign bus_dec = bus_q - 12'd1;
	assign wr_hit  = (kind == KIND_DATA_WR) && addressed;
	assign rd_hit  = (kind == KIND_DATA_RD) && addressed;
	assign cnt_hit = rd_hit && second && (off == OFF_OSC_LO);

	// Configuration space read mux
	always_comb begin
		case (off)
			OFF_VENDOR_LO: rd_byte = VENDOR_ID[7:0];
			OFF_VENDOR_HI: rd_byte = VENDOR_ID[15:8];
			OFF_DEVICE_ID: rd_byte = second ? 8'h02 : 8'h01;
			OFF_CMD_LOW:   rd_byte = cmd_low_q;
			OFF_CMD_HIGH:  rd_byte = cmd_high_q;
			OFF_STATUS_HI: rd_byte = 8'h80;
			OFF_REV:       rd_byte = 8'h02;
			OFF_CLASS:     rd_byte = 8'h04;
			OFF_BAR0:      rd_byte = BAR_LOW_BYTE;
			OFF_BAR1:      rd_byte = INITIAL_BAR[15:8];
			OFF_BAR2:      rd_byte = INITIAL_BAR[23:16];
			OFF_BAR3:      rd_byte = bar_top_q;
			OFF_INT_LINE:  rd_byte = 8'hff;
			OFF_EXT1:      rd_byte = second ? 8'h40 : 8'h00;
			OFF_EXT2:      rd_byte = second ? 8'h01 : 8'h00;
			OFF_OSC_LO:    rd_byte = second ? osc_inc[7:0] : 8'h00;
			OFF_OSC_HI:    rd_byte = second ? osc_q[15:8] : 8'h00;
			OFF_BUS_LO:    rd_byte = second ? bus_q[7:0] : 8'h00;
			OFF_BUS_HI:    rd_byte = second ? {4'd0, bus_q[11:8]} : 8'h00;
			default:       rd_byte = 8'h00;
		endcase
	end

	// BAR top byte as it stands after this access
	assign bar_top_next = (wr_hit && off == OFF_BAR3) ? data[7:0] : bar_top_q;

	// Result of the access
	always_comb begin
		res = '0;
		res.bar_base = {bar_top_next, INITIAL_BAR[23:4], 4'd0};
		case (kind)
			KIND_ADDR_RD: res.read_data = address_q;
			KIND_DATA_RD: res.read_data = addressed ? {24'd0, rd_byte}
				: {24'd0, NO_DEVICE_BYTE};
			KIND_DATA_WR: begin
				if (wr_hit) begin
					if (off >= OFF_BAR0 && off <= OFF_BAR3) begin
						res.bar_changed = 1'b1;
					end else if (off == OFF_INIT_EN) begin
						res.init_enable_pulse = 1'b1;
						res.init_enable_value = data[2:0];
					end else if (off == OFF_ENABLE) begin
						res.enable_pulse = 1'b1;
						res.enable_value = 1'b1;
					end else if (off == OFF_DISABLE) begin
						res.enable_pulse = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// State update on a taken access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q  <= '0;
			cmd_low_q  <= CMD_LOW_RST;
			cmd_high_q <= '0;
			bar_top_q  <= INITIAL_BAR[31:24];
			osc_q      <= '0;
			bus_q      <= '0;
		end else if (accept) begin
			if (kind == KIND_ADDR_WR) begin
				address_q <= data;
			end
			if (wr_hit && off == OFF_CMD_LOW) begin
				cmd_low_q <= (data[7:0] & CMD_LOW_MASK) | (cmd_low_q & ~CMD_LOW_MASK);
			end
			if (wr_hit && off == OFF_CMD_HIGH) begin
				cmd_high_q <= (data[7:0] & CMD_HIGH_MASK) | (cmd_high_q & ~CMD_HIGH_MASK);
			end
			bar_top_q <= bar_top_next;
			if (cnt_hit) begin
				osc_q <= osc_inc;
				bus_q <= bus_dec;
			end
		end
	end

endmodule

// ----- rtl/pcicfg_obuf.sv -----
// ----------------------------------------------------------------------------
// pcicfg_obuf
// Result register with a skid stage, so an access can be taken while an
// earlier result still waits at the output.
// ----------------------------------------------------------------------------
module pcicfg_obuf
	import pcicfg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t main_q;
	res_t skid_q;
	logic main_vld_q;
	logic skid_vld_q;
	logic push;
	logic take;

	assign in_ready  = !skid_vld_q;
	assign push      = in_valid && in_ready;
	assign take      = main_vld_q && out_ready;
	assign out_valid = main_vld_q;
	assign out_res   = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					main_vld_q <= push;
				end
			end else if (push) begin
				if (main_vld_q) begin
					skid_vld_q <= 1'b1;
				end else begin
					main_vld_q <= 1'b1;
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= in_res;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_q <= in_res;
			end else begin
				main_q <= in_res;
			end
		end
	end

endmodule
